/* src/pct_pkg.sv */
// Package for the disc pair collision-time pipeline.
// Holds the widths, outcome codes and the stage payload structs.
// No dependencies; every pct module imports it.
package pct_pkg;

  localparam int CB  = 32;           // coordinate width
  localparam int FB  = 16;           // fractional bits
  localparam int TB  = 48;           // time width
  localparam int DW  = CB + 1;       // differences
  localparam int PW  = 2 * DW;       // signed products
  localparam int SW  = PW + 1;       // sums of products
  localparam int MW  = PW;           // magnitudes of dot products
  localparam int HW  = MW / 2;       // half of a magnitude
  localparam int QW  = 2 * MW;       // discriminant terms
  localparam int RMW = MW + 3;       // square root remainder
  localparam int NSQ = MW;           // square root stages
  localparam int NDV = TB;           // divider stages
  localparam int LAT = 3 + 3 + NSQ + 1 + NDV;

  localparam logic [2:0] OUT_HIT  = 3'd0;
  localparam logic [2:0] OUT_SEP  = 3'd1;
  localparam logic [2:0] OUT_OVL  = 3'd2;
  localparam logic [2:0] OUT_MISS = 3'd3;
  localparam logic [2:0] OUT_SAME = 3'd4;

  typedef struct packed {
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] dvx;
    logic [DW-1:0] dvy;
    logic [CB-1:0] sig;
    logic          same;
  } pct_diff_t;

  typedef struct packed {
    logic [PW-1:0]   xv;
    logic [PW-1:0]   yv;
    logic [PW-1:0]   vvx;
    logic [PW-1:0]   vvy;
    logic [PW-1:0]   rrx;
    logic [PW-1:0]   rry;
    logic [2*CB-1:0] sig2;
    logic            same;
  } pct_prod_t;

  typedef struct packed {
    logic [2:0]    outcome;
    logic [MW-1:0] a;      // -dv.dr
    logic [MW-1:0] dvdv;
    logic [MW-1:0] gap;
  } pct_mag_t;

  typedef struct packed {
    logic [2:0]      outcome;
    logic [MW-1:0]   a;
    logic [MW-1:0]   dvdv;
    logic [QW-1:0]   dsh;
    logic [MW-1:0]   root;
    logic [RMW-1:0]  rem;
  } pct_root_t;

  typedef struct packed {
    logic [2:0]    outcome;
    logic          sat;
    logic [MW-1:0] dvdv;
    logic [MW:0]   rem;
    logic [TB-1:0] nlow;
    logic [TB-1:0] quo;
  } pct_div_t;

endpackage

/* src/pct_front.sv */
// Front stages: relative motion, dot products and early outcome tests.
// Three register stages; depends on pct_pkg.
module pct_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [31:0]        pos_x_a_i,
  input  logic [31:0]        pos_y_a_i,
  input  logic [31:0]        vel_x_a_i,
  input  logic [31:0]        vel_y_a_i,
  input  logic [30:0]        rad_a_i,
  input  logic [31:0]        pos_x_b_i,
  input  logic [31:0]        pos_y_b_i,
  input  logic [31:0]        vel_x_b_i,
  input  logic [31:0]        vel_y_b_i,
  input  logic [30:0]        rad_b_i,
  input  logic               same_disc_i,
  output logic               vld_o,
  output pct_pkg::pct_mag_t  data_o
);
  import pct_pkg::*;

  logic      v1_q, v2_q, v3_q;
  pct_diff_t s1_d, s1_q;
  pct_prod_t s2_d, s2_q;
  pct_mag_t  s3_d, s3_q;
  logic [SW-1:0] dvdr, dvdv_w, drdr_w, gap_w, neg_dvdr;

  always_comb begin
    s1_d.dx   = {pos_x_b_i[CB-1], pos_x_b_i} - {pos_x_a_i[CB-1], pos_x_a_i};
    s1_d.dy   = {pos_y_b_i[CB-1], pos_y_b_i} - {pos_y_a_i[CB-1], pos_y_a_i};
    s1_d.dvx  = {vel_x_b_i[CB-1], vel_x_b_i} - {vel_x_a_i[CB-1], vel_x_a_i};
    s1_d.dvy  = {vel_y_b_i[CB-1], vel_y_b_i} - {vel_y_a_i[CB-1], vel_y_a_i};
    s1_d.sig  = {1'b0, rad_a_i} + {1'b0, rad_b_i};
    s1_d.same = same_disc_i;
  end

  always_comb begin
    s2_d.xv   = $signed(s1_q.dx) * $signed(s1_q.dvx);
    s2_d.yv   = $signed(s1_q.dy) * $signed(s1_q.dvy);
    s2_d.vvx  = $signed(s1_q.dvx) * $signed(s1_q.dvx);
    s2_d.vvy  = $signed(s1_q.dvy) * $signed(s1_q.dvy);
    s2_d.rrx  = $signed(s1_q.dx) * $signed(s1_q.dx);
    s2_d.rry  = $signed(s1_q.dy) * $signed(s1_q.dy);
    s2_d.sig2 = s1_q.sig * s1_q.sig;
    s2_d.same = s1_q.same;
  end

  always_comb begin
    dvdr     = {s2_q.xv[PW-1], s2_q.xv} + {s2_q.yv[PW-1], s2_q.yv};
    dvdv_w   = {1'b0, s2_q.vvx} + {1'b0, s2_q.vvy};
    drdr_w   = {1'b0, s2_q.rrx} + {1'b0, s2_q.rry};
    gap_w    = drdr_w - {{(SW-2*CB){1'b0}}, s2_q.sig2};
    neg_dvdr = ~dvdr + {{(SW-1){1'b0}}, 1'b1};
    s3_d.a    = neg_dvdr[MW-1:0];
    s3_d.dvdv = dvdv_w[MW-1:0];
    s3_d.gap  = gap_w[MW-1:0];
    priority if (s2_q.same)  s3_d.outcome = OUT_SAME;
    else if (!dvdr[SW-1])    s3_d.outcome = OUT_SEP;
    else if (gap_w[SW-1])    s3_d.outcome = OUT_OVL;
    else                     s3_d.outcome = OUT_HIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign vld_o  = v3_q;
  assign data_o = s3_q;

endmodule

/* src/pct_disc.sv */
// Discriminant stages: (dv.dr)^2 - dv.dv * gap from half-width partial products.
// Three register stages; depends on pct_pkg.
module pct_disc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  pct_pkg::pct_mag_t  data_i,
  output logic               vld_o,
  output pct_pkg::pct_root_t data_o
);
  import pct_pkg::*;

  typedef struct packed {
    logic [2:0]      outcome;
    logic [MW-1:0]   a;
    logic [MW-1:0]   dvdv;
    logic [2*HW-1:0] ahh, ahl, all_p, ghh, ghl, glh, gll;
  } pct_part_t;

  typedef struct packed {
    logic [2:0]    outcome;
    logic [MW-1:0] a;
    logic [MW-1:0] dvdv;
    logic [QW-1:0] p1;
    logic [QW-1:0] p2;
  } pct_term_t;

  logic      v4_q, v5_q, v6_q;
  pct_part_t s4_d, s4_q;
  pct_term_t s5_d, s5_q;
  pct_root_t s6_d, s6_q;
  logic [QW:0] dw;

  always_comb begin
    s4_d.outcome = data_i.outcome;
    s4_d.a       = data_i.a;
    s4_d.dvdv    = data_i.dvdv;
    s4_d.ahh   = data_i.a[MW-1:HW] * data_i.a[MW-1:HW];
    s4_d.ahl   = data_i.a[MW-1:HW] * data_i.a[HW-1:0];
    s4_d.all_p = data_i.a[HW-1:0] * data_i.a[HW-1:0];
    s4_d.ghh   = data_i.dvdv[MW-1:HW] * data_i.gap[MW-1:HW];
    s4_d.ghl   = data_i.dvdv[MW-1:HW] * data_i.gap[HW-1:0];
    s4_d.glh   = data_i.dvdv[HW-1:0] * data_i.gap[MW-1:HW];
    s4_d.gll   = data_i.dvdv[HW-1:0] * data_i.gap[HW-1:0];
  end

  always_comb begin
    s5_d.outcome = s4_q.outcome;
    s5_d.a       = s4_q.a;
    s5_d.dvdv    = s4_q.dvdv;
    s5_d.p1 = ({{(QW-2*HW){1'b0}}, s4_q.ahh} << (2*HW))
            + ({{(QW-2*HW){1'b0}}, s4_q.ahl} << (HW+1))
            +  {{(QW-2*HW){1'b0}}, s4_q.all_p};
    s5_d.p2 = ({{(QW-2*HW){1'b0}}, s4_q.ghh} << (2*HW))
            + ({{(QW-2*HW){1'b0}}, s4_q.ghl} << HW)
            + ({{(QW-2*HW){1'b0}}, s4_q.glh} << HW)
            +  {{(QW-2*HW){1'b0}}, s4_q.gll};
  end

  always_comb begin
    dw = {1'b0, s5_q.p1} - {1'b0, s5_q.p2};
    s6_d.outcome = (s5_q.outcome == OUT_HIT && dw[QW]) ? OUT_MISS : s5_q.outcome;
    s6_d.a    = s5_q.a;
    s6_d.dvdv = s5_q.dvdv;
    s6_d.dsh  = dw[QW-1:0];
    s6_d.root = '0;
    s6_d.rem  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= vld_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  assign vld_o  = v6_q;
  assign data_o = s6_q;

endmodule

/* src/pct_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Depends on pct_pkg.
module pct_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  pct_pkg::pct_root_t data_i,
  output logic               vld_o,
  output pct_pkg::pct_root_t data_o
);
  import pct_pkg::*;

  logic      vld_q [NSQ];
  pct_root_t st_q  [NSQ];

  for (genvar i = 0; i < NSQ; i++) begin : g_stage
    logic          cur_v;
    pct_root_t     cur, nxt;
    logic [RMW-1:0] r2, trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign cur_v = vld_i;
      assign cur   = data_i;
    end else begin : g_next
      assign cur_v = vld_q[i-1];
      assign cur   = st_q[i-1];
    end

    always_comb begin
      r2    = {cur.rem[RMW-3:0], cur.dsh[QW-1:QW-2]};
      trial = {{(RMW-MW-2){1'b0}}, cur.root, 2'b01};
      ge    = (r2 >= trial);
      nxt         = cur;
      nxt.rem     = ge ? (r2 - trial) : r2;
      nxt.root    = {cur.root[MW-2:0], ge};
      nxt.dsh     = {cur.dsh[QW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign vld_o  = vld_q[NSQ-1];
  assign data_o = st_q[NSQ-1];

endmodule

/* src/pct_div.sv */
// Numerator, saturation test and pipelined restoring divider, one quotient
// bit per register stage. Last stage is the output register. Depends on pct_pkg.
module pct_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  pct_pkg::pct_root_t data_i,
  output logic               vld_o,
  output logic [2:0]         outcome_o,
  output logic [47:0]        hit_time_o
);
  import pct_pkg::*;

  logic          v0_q;
  pct_div_t      s0_d, s0_q;
  logic [MW-1:0] num;
  logic          vld_q [NDV];
  pct_div_t      st_q  [NDV];

  always_comb begin
    num = data_i.a - data_i.root;
    s0_d.outcome = data_i.outcome;
    s0_d.dvdv    = data_i.dvdv;
    // quotient reaches 2^TB exactly when num >= dvdv << (TB-FB)
    s0_d.sat  = ({{(TB-FB){1'b0}}, num[MW-1:TB-FB]} >= data_i.dvdv);
    s0_d.rem  = {{(TB-FB+1){1'b0}}, num[MW-1:TB-FB]};
    s0_d.nlow = {num[TB-FB-1:0], {FB{1'b0}}};
    s0_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q <= s0_d;
    end
  end

  for (genvar i = 0; i < NDV; i++) begin : g_stage
    logic       cur_v;
    pct_div_t   cur, nxt;
    logic [MW:0] r2, den;
    logic       ge;

    if (i == 0) begin : g_first
      assign cur_v = v0_q;
      assign cur   = s0_q;
    end else begin : g_next
      assign cur_v = vld_q[i-1];
      assign cur   = st_q[i-1];
    end

    always_comb begin
      r2  = {cur.rem[MW-1:0], cur.nlow[TB-1]};
      den = {1'b0, cur.dvdv};
      ge  = (r2 >= den);
      nxt      = cur;
      nxt.rem  = ge ? (r2 - den) : r2;
      nxt.quo  = {cur.quo[TB-2:0], ge};
      nxt.nlow = {cur.nlow[TB-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign vld_o      = vld_q[NDV-1];
  assign outcome_o  = st_q[NDV-1].outcome;
  assign hit_time_o = (st_q[NDV-1].outcome == OUT_HIT && !st_q[NDV-1].sat)
                    ? st_q[NDV-1].quo : '1;

endmodule

/* src/pair_collision_time.sv */
// Collision-time predictor for a pair of discs under straight-line motion.
// Input channel (in_valid_i/in_ready_o) carries one pair beat: positions,
// velocities in signed Q16.16, radii in unsigned Q15.16 and a same-particle
// flag. Output channel (out_valid_o/out_ready_i) carries one result beat: an
// outcome code (hit, separating, overlapping, miss, same particle) and the hit
// time in Q32.16, all ones unless a hit, saturating at 2^48-1.
// The pipeline has 3 front stages, 3 discriminant stages, 66 square root
// stages (one root bit each), 1 numerator stage and 48 divider stages (one
// quotient bit each). Throughput is one beat per cycle when not stalled.
// Every stage advances together; when a result sits at the output and the
// receiver stalls, the whole pipeline holds and in_ready_o drops in the same
// cycle, so nothing is lost or repeated. in_ready_o = out_ready_i or no
// result waiting.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// Depends on pct_pkg, pct_front, pct_disc, pct_sqrt and pct_div.
module pair_collision_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_x_a_i,
  input  logic [31:0] pos_y_a_i,
  input  logic [31:0] vel_x_a_i,
  input  logic [31:0] vel_y_a_i,
  input  logic [30:0] rad_a_i,
  input  logic [31:0] pos_x_b_i,
  input  logic [31:0] pos_y_b_i,
  input  logic [31:0] vel_x_b_i,
  input  logic [31:0] vel_y_b_i,
  input  logic [30:0] rad_b_i,
  input  logic        same_disc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [47:0] hit_time_o
);
  import pct_pkg::*;

  logic      en;
  logic      f_vld, d_vld, s_vld;
  pct_mag_t  f_data;
  pct_root_t d_data, s_data;

  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  pct_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .pos_x_a_i, .pos_y_a_i, .vel_x_a_i, .vel_y_a_i, .rad_a_i,
    .pos_x_b_i, .pos_y_b_i, .vel_x_b_i, .vel_y_b_i, .rad_b_i,
    .same_disc_i,
    .vld_o(f_vld), .data_o(f_data)
  );

  pct_disc u_disc (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .data_i(f_data),
    .vld_o(d_vld), .data_o(d_data)
  );

  pct_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(d_vld), .data_i(d_data),
    .vld_o(s_vld), .data_o(s_data)
  );

  pct_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld), .data_i(s_data),
    .vld_o(out_valid_o), .outcome_o, .hit_time_o
  );

endmodule

/* src/pct_checker.sv */
// Port-level checks for pair_collision_time, attached by bind.
// Depends on pct_pkg.
module pct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  outcome_o,
  input logic [47:0] hit_time_o
);
  import pct_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o)
      && $stable(hit_time_o))
    else $error("result beat changed while stalled");

  // ready follows the output stall only
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (out_ready_i || !out_valid_o))
    else $error("input ready does not match output stall");

  // only a hit carries a finite time
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OUT_HIT |-> hit_time_o == '1)
    else $error("non-hit result with finite time");

endmodule

bind pair_collision_time pct_checker u_pct_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .outcome_o, .hit_time_o
);

/* dv/pct_checker.sv */
// Checker for pair_collision_time: watches both channels, predicts each
// result from the accepted pair beat and compares in order. Uses pct_pkg.
module pct_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] pos_x_a_i,
  input  logic [31:0] pos_y_a_i,
  input  logic [31:0] vel_x_a_i,
  input  logic [31:0] vel_y_a_i,
  input  logic [30:0] rad_a_i,
  input  logic [31:0] pos_x_b_i,
  input  logic [31:0] pos_y_b_i,
  input  logic [31:0] vel_x_b_i,
  input  logic [31:0] vel_y_b_i,
  input  logic [30:0] rad_b_i,
  input  logic        same_disc_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  outcome_i,
  input  logic [47:0] hit_time_i,
  output int          errors_o,
  output int          pending_o,
  output int          hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pct_pkg::*;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [47:0] hit_time;
  } collision_t;

  collision_t expected_q[$];
  int         errors;
  int         hits;
  int         pending;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign hits_o    = hits;

  function automatic logic [255:0] floor_sqrt(logic [255:0] n);
    logic [255:0] root;
    logic [255:0] trial;
    root = '0;
    for (int b = 127; b >= 0; b--) begin
      trial = root | (256'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic collision_t predict_collision(
      logic signed [31:0] xa, ya, vxa, vya, xb, yb, vxb, vyb,
      logic [30:0] ra, rb, logic same);
    collision_t r;
    logic signed [255:0] dx, dy, dvx, dvy, dvdr, dvdv, drdr, sig, gap, d, num, q;
    r.outcome  = OUT_HIT;
    r.hit_time = '1;
    if (same) begin
      r.outcome = OUT_SAME;
      return r;
    end
    dx  = 256'(xb) - 256'(xa);
    dy  = 256'(yb) - 256'(ya);
    dvx = 256'(vxb) - 256'(vxa);
    dvy = 256'(vyb) - 256'(vya);
    dvdr = dx * dvx + dy * dvy;
    dvdv = dvx * dvx + dvy * dvy;
    drdr = dx * dx + dy * dy;
    if (dvdr >= 0) begin
      r.outcome = OUT_SEP;
      return r;
    end
    sig = $signed({225'd0, ra}) + $signed({225'd0, rb});
    gap = drdr - sig * sig;
    if (gap < 0) begin
      r.outcome = OUT_OVL;
      return r;
    end
    d = dvdr * dvdr - dvdv * gap;
    if (d < 0) begin
      r.outcome = OUT_MISS;
      return r;
    end
    num = -(dvdr + $signed(floor_sqrt(d)));
    q = (num <<< FB) / dvdv;
    r.hit_time = (q >= (256'sd1 <<< 48)) ? '1 : q[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    collision_t want;
    if (!rst_ni) begin
      expected_q.delete();
      errors  = 0;
      hits    = 0;
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", {61'd0, outcome_i}, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (outcome_i !== want.outcome)
            report_mismatch("outcome", {61'd0, outcome_i}, {61'd0, want.outcome});
          if (hit_time_i !== want.hit_time)
            report_mismatch("hit_time", {16'd0, hit_time_i}, {16'd0, want.hit_time});
          if (want.outcome == OUT_HIT) hits++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_collision(pos_x_a_i, pos_y_a_i, vel_x_a_i,
            vel_y_a_i, pos_x_b_i, pos_y_b_i, vel_x_b_i, vel_y_b_i, rad_a_i,
            rad_b_i, same_disc_i));
      pending = expected_q.size();
    end
  end
endmodule

/* dv/tb_pair_collision_time.sv */
// Testbench top for pair_collision_time: drives pair beats with bursts and
// gaps, stalls the result side, and gives the verdict. Uses pct_scoreboard, pct_pkg.
module tb_pair_collision_time;
  timeunit 1ns;
  timeprecision 1ps;
  import pct_pkg::*;

  localparam int NUM_RANDOM = 1830;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [31:0] pos_x_a_i = 0, pos_y_a_i = 0, vel_x_a_i = 0, vel_y_a_i = 0;
  logic [31:0] pos_x_b_i = 0, pos_y_b_i = 0, vel_x_b_i = 0, vel_y_b_i = 0;
  logic [30:0] rad_a_i = 0, rad_b_i = 0;
  logic        same_disc_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [2:0]  outcome_o;
  logic [47:0] hit_time_o;
  int          errors, pending, hits;
  int          cycles = 0;
  int          sent = 0;
  bit          long_stall = 0;
  bit          stall_done = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  pair_collision_time uut (.*);

  pct_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .pos_x_a_i, .pos_y_a_i, .vel_x_a_i, .vel_y_a_i, .rad_a_i,
    .pos_x_b_i, .pos_y_b_i, .vel_x_b_i, .vel_y_b_i, .rad_b_i, .same_disc_i,
    .out_valid_i(out_valid_o), .out_ready_i, .outcome_i(outcome_o),
    .hit_time_i(hit_time_o), .errors_o(errors), .pending_o(pending), .hits_o(hits)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall pattern, mostly ready, overridden by long hold-off.
  always @(posedge clk_i) begin
    if (long_stall) out_ready_i <= 1'b0;
    else if (sent < 100 || sent > 1500) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [31:0] rand_coord(int mode);
    unique case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // Present one beat and hold it until accepted.
  task automatic send_pair(logic [31:0] xa, ya, vxa, vya, logic [30:0] ra,
                           logic [31:0] xb, yb, vxb, vyb, logic [30:0] rb,
                           logic same);
    in_valid_i  <= 1'b1;
    pos_x_a_i <= xa; pos_y_a_i <= ya; vel_x_a_i <= vxa; vel_y_a_i <= vya;
    rad_a_i <= ra;
    pos_x_b_i <= xb; pos_y_b_i <= yb; vel_x_b_i <= vxb; vel_y_b_i <= vyb;
    rad_b_i <= rb;
    same_disc_i <= same;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random();
    int m;
    logic [31:0] xa, ya, xb, yb, vxa, vya, vxb, vyb;
    logic [30:0] ra, rb;
    m = $urandom_range(0, 9);
    if (m < 7) begin
      // aim b roughly at a so most pairs reach the hit path
      xa = rand_coord(1); ya = rand_coord(1);
      xb = rand_coord(1); yb = rand_coord(1);
      vxa = rand_coord(2); vya = rand_coord(2);
      vxb = 32'($signed(vxa) + ($signed(xa) - $signed(xb)) / 8 + $signed(rand_coord(2)) / 4);
      vyb = 32'($signed(vya) + ($signed(ya) - $signed(yb)) / 8 + $signed(rand_coord(2)) / 4);
      ra = 31'($urandom_range(0, 3 << 16)); rb = 31'($urandom_range(0, 3 << 16));
    end else begin
      xa = rand_coord(0); ya = rand_coord(0); xb = rand_coord(0); yb = rand_coord(0);
      vxa = rand_coord(0); vya = rand_coord(0); vxb = rand_coord(0); vyb = rand_coord(0);
      ra = 31'($urandom); rb = 31'($urandom);
    end
    send_pair(xa, ya, vxa, vya, ra, xb, yb, vxb, vyb, rb, ($urandom_range(0, 39) == 0));
  endtask

  initial begin
    int gap;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: same particle, separating, zero motion, overlap, miss, touch,
    // head-on hit, saturated time, field extremes.
    send_pair(0, 0, 0, 0, 31'(1 << 16), 0, 0, 0, 0, 31'(1 << 16), 1);
    send_pair(0, 0, 0, 0, 31'(1 << 16), 10 << 16, 0, 1 << 16, 0, 31'(1 << 16), 0);
    send_pair(0, 0, 5, 5, 31'(1 << 16), 10 << 16, 0, 5, 5, 31'(1 << 16), 0);
    send_pair(0, 0, 1 << 16, 0, 31'(2 << 16), 1 << 16, 0, 0, 0, 31'(2 << 16), 0);
    send_pair(0, 0, 0, 0, 31'(1 << 16), 10 << 16, 10 << 16, -(1 << 16), 0,
              31'(1 << 16), 0);
    send_pair(0, 0, 1 << 16, 0, 31'(1 << 16), 2 << 16, 0, 0, 0, 31'(1 << 16), 0);
    send_pair(0, 0, 0, 0, 31'(1 << 16), 10 << 16, 0, -(1 << 16), 0, 31'(1 << 16), 0);
    send_pair(0, 0, 0, 0, 0, 32'h7fffffff, 0, 32'hffffffff, 0, 0, 0);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '1,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, '1, 0);
    send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, '1,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '1, 0);
    send_pair(32'h80000000, 0, 32'h7fffffff, 0, 0,
              32'h7fffffff, 0, 32'h80000000, 0, 0, 0);
    send_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1);
    send_pair(0, 0, 0, 0, '1, 0, 1, 0, 1, '1, 0);
    // Wait for the pipeline to drain.
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    while (sent < NUM_RANDOM + 13) begin
      if (!stall_done && sent >= 400) begin
        stall_done = 1;
        long_stall = 1;
        fork
          begin
            repeat (300) @(posedge clk_i);
            long_stall = 0;
          end
        join_none
      end
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 30)) send_random();
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 20) @(posedge clk_i);
    $display("sent %0d pair beats, %0d hits among them, with bursts and stalls",
             sent, hits);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
